### design/lcts_pkg.sv
`timescale 1ns / 1ps

package lcts_pkg;

    // fixed field widths
    localparam int RAW_W     = 24;
    localparam int TARED_W   = 25;
    localparam int ALPHA_W   = 17;
    localparam int FRAC_W    = 16;
    localparam int FILT_W    = 41;
    localparam int OUT_DROP  = 8;
    localparam int SMOOTH_W  = FILT_W - OUT_DROP;
    localparam int OPCODE_W  = 2;

    // filter weight constants, unsigned Q1.16
    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'h10000;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd6554;

    // request opcodes
    localparam logic [OPCODE_W-1:0] OP_SAMPLE    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_TARE      = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LOAD_OFFS = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0]     opcode;
        logic [RAW_W-1:0]        raw_word;
        logic signed [RAW_W-1:0] new_offset_value;
    } item_t;

    typedef struct packed {
        logic signed [SMOOTH_W-1:0] avg_load;
        logic signed [TARED_W-1:0]  tared_counts;
        logic signed [RAW_W-1:0]    current_offset;
        logic                       taring;
    } result_t;

endpackage

### design/lcts_offset_div.sv
`timescale 1ns / 1ps

// tare sum divided by the sample count, truncated toward zero,
// done as a reciprocal multiply on the magnitude
module lcts_offset_div #(
    parameter int TARE_SAMPLES = 10
) (
    input  logic signed [lcts_pkg::RAW_W+$clog2(TARE_SAMPLES)-1:0] tare_sum,
    output logic signed [lcts_pkg::RAW_W-1:0]                      offset
);

    localparam int SUM_W   = lcts_pkg::RAW_W + $clog2(TARE_SAMPLES);
    localparam int SHIFT   = SUM_W + $clog2(TARE_SAMPLES);
    localparam int RECIP_W = SHIFT + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
        ((64'd1 << SHIFT) + 64'(TARE_SAMPLES) - 64'd1) / 64'(TARE_SAMPLES));

    logic                             sum_neg;
    logic [SUM_W-1:0]                 sum_mag;
    logic [PROD_W-1:0]                prod;
    logic [lcts_pkg::RAW_W-1:0]       quot_mag;

    // magnitude, scaled reciprocal, restore sign
    assign sum_neg  = tare_sum[SUM_W-1];
    assign sum_mag  = sum_neg ? SUM_W'(-tare_sum) : SUM_W'(tare_sum);
    assign prod     = PROD_W'(sum_mag) * PROD_W'(RECIP);
    assign quot_mag = prod[SHIFT +: lcts_pkg::RAW_W];
    assign offset   = sum_neg ? $signed(-quot_mag) : $signed(quot_mag);

endmodule

### design/lcts_core.sv
`timescale 1ns / 1ps

// holds offset, average and tare state; computes one result per request
module lcts_core #(
    parameter int TARE_SAMPLES = 10
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  lcts_pkg::item_t                      item,
    input  logic [lcts_pkg::ALPHA_W-1:0]         alpha,
    output lcts_pkg::result_t                    result
);

    localparam int SUM_W = lcts_pkg::RAW_W + $clog2(TARE_SAMPLES);
    localparam int CNT_W = $clog2(TARE_SAMPLES + 1);
    localparam int NEW_W = lcts_pkg::ALPHA_W + 1 + lcts_pkg::TARED_W;
    localparam int OLD_W = lcts_pkg::ALPHA_W + 1 + lcts_pkg::FILT_W;
    localparam int ACC_W = NEW_W;

    logic signed [lcts_pkg::RAW_W-1:0]   offset_reg, offset_next;
    logic signed [lcts_pkg::FILT_W-1:0]  filt_reg, filt_next;
    logic signed [SUM_W-1:0]             sum_reg, sum_next;
    logic [CNT_W-1:0]                    count_reg, count_next;
    logic                                active_reg, active_next;

    logic signed [lcts_pkg::RAW_W-1:0]   raw_s;
    logic signed [lcts_pkg::TARED_W-1:0] tared_diff, tared_out;
    logic [lcts_pkg::ALPHA_W-1:0]        alpha_eff, beta;
    logic signed [NEW_W-1:0]             new_term;
    logic signed [OLD_W-1:0]             old_prod;
    logic signed [ACC_W-1:0]             old_term, filt_sum;
    logic signed [SUM_W-1:0]             sum_inc;
    logic [CNT_W-1:0]                    count_inc;
    logic                                tare_done;
    logic signed [lcts_pkg::RAW_W-1:0]   tare_offset;

    // sample minus held offset
    assign raw_s      = $signed(item.raw_word);
    assign tared_diff = lcts_pkg::TARED_W'(raw_s) - lcts_pkg::TARED_W'(offset_reg);

    // weight saturates at one
    assign alpha_eff = (alpha > lcts_pkg::ALPHA_ONE) ? lcts_pkg::ALPHA_ONE : alpha;
    assign beta      = lcts_pkg::ALPHA_ONE - alpha_eff;

    // f' = a*d + floor((1 - a) * f), average kept with 16 fraction bits
    assign new_term = $signed({1'b0, alpha_eff}) * tared_diff;
    assign old_prod = $signed({1'b0, beta}) * filt_reg;
    assign old_term = ACC_W'(old_prod >>> lcts_pkg::FRAC_W);
    assign filt_sum = new_term + old_term;

    // tare accumulation
    assign sum_inc   = sum_reg + SUM_W'(raw_s);
    assign count_inc = count_reg + CNT_W'(1);
    assign tare_done = (count_inc >= CNT_W'(TARE_SAMPLES));

    lcts_offset_div #(
        .TARE_SAMPLES (TARE_SAMPLES)
    ) u_offset_div (
        .tare_sum (sum_inc),
        .offset   (tare_offset)
    );

    // next state per opcode
    always_comb
    begin
        offset_next = offset_reg;
        filt_next   = filt_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        active_next = active_reg;
        tared_out   = '0;
        unique case (item.opcode)
            lcts_pkg::OP_SAMPLE:
            begin
                if (active_reg)
                begin
                    if (tare_done)
                    begin
                        offset_next = tare_offset;
                        filt_next   = '0;
                        active_next = 1'b0;
                        count_next  = '0;
                        sum_next    = '0;
                    end
                    else
                    begin
                        sum_next   = sum_inc;
                        count_next = count_inc;
                    end
                end
                else
                begin
                    tared_out = tared_diff;
                    filt_next = filt_sum[lcts_pkg::FILT_W-1:0];
                end
            end
            lcts_pkg::OP_TARE:
            begin
                active_next = 1'b1;
                sum_next    = '0;
                count_next  = '0;
            end
            lcts_pkg::OP_LOAD_OFFS:
            begin
                offset_next = item.new_offset_value;
            end
            default:
            begin
                offset_next = offset_reg;
            end
        endcase
    end

    // result reflects state after this request
    always_comb
    begin
        result.avg_load       = filt_next[lcts_pkg::FILT_W-1:lcts_pkg::OUT_DROP];
        result.tared_counts   = tared_out;
        result.current_offset = offset_next;
        result.taring         = active_next;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            filt_reg   <= '0;
            sum_reg    <= '0;
            count_reg  <= '0;
            active_reg <= 1'b0;
        end
        else if (advance)
        begin
            offset_reg <= offset_next;
            filt_reg   <= filt_next;
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            active_reg <= active_next;
        end
    end

endmodule

### design/load_cell_tare_and_smooth.sv
`timescale 1ns / 1ps
// A request passes through an input register, then a result register.
// Throughput: one request per cycle while the result side is not stalled;
// the average's multiply-add feedback closes between the input and result
// registers.
// Reset (rst_n low, asynchronous): offset, average and tare state cleared,
// smoothing_alpha back to 6554, both stream stages empty.
module load_cell_tare_and_smooth #(
    parameter int TARE_SAMPLES = 10
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [23:0] raw_word, [47:24] new_offset_value
    input  logic [47:0] s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [32:0] avg_load, [57:33] tared_counts, [81:58] current_offset, [87:82] zero
    output logic [87:0] m_axis_tdata,
    // [0] taring
    output logic [0:0]  m_axis_tuser,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    // smoothing_alpha
    input  logic [16:0] cfg_data
);

    logic                              in_valid_reg;
    lcts_pkg::item_t                   in_item_reg;
    logic                              out_valid_reg;
    lcts_pkg::result_t                 out_result_reg;
    logic [lcts_pkg::ALPHA_W-1:0]      alpha_reg;
    logic                              advance;
    logic                              accept;
    lcts_pkg::result_t                 core_result;

    // handshake: item moves on whenever the result slot is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            alpha_reg     <= lcts_pkg::ALPHA_RESET;
        end
        else
        begin
            if (accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
                alpha_reg <= cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg.opcode           <= s_axis_tuser;
            in_item_reg.raw_word         <= s_axis_tdata[23:0];
            in_item_reg.new_offset_value <= $signed(s_axis_tdata[47:24]);
        end
        if (advance)
            out_result_reg <= core_result;
    end

    lcts_core #(
        .TARE_SAMPLES (TARE_SAMPLES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .alpha   (alpha_reg),
        .result  (core_result)
    );

    // output packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0,
                            out_result_reg.current_offset,
                            out_result_reg.tared_counts,
                            out_result_reg.avg_load};
    assign m_axis_tuser  = out_result_reg.taring;

endmodule

### bench/tb_load_cell_tare_and_smooth.sv
`timescale 1ns / 1ps

module tb_load_cell_tare_and_smooth;

    localparam int CLK_PERIOD      = 10;
    localparam int TARE_SAMPLES    = 10;
    localparam int ITEMS_PER_PHASE = 270;
    localparam int NUM_PHASES      = 6;
    localparam int HOLD_CYCLES     = 80;
    // cycles with no request, result or register write accepted
    localparam int WATCHDOG_LIMIT  = 2000;

    // opcode 3 has no name in the package, the block treats it as a no-op
    localparam logic [lcts_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        lcts_pkg::item_t   req;
        bit                fixed;
        lcts_pkg::result_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [16:0] cfg_data = '0;

    // predictor state
    logic [lcts_pkg::ALPHA_W-1:0]      alpha_reg = lcts_pkg::ALPHA_RESET;
    logic signed [lcts_pkg::RAW_W-1:0] held_offset = '0;
    longint                            avg_q16 = 0;
    int                                tare_acc = 0;
    int unsigned                       tare_seen = 0;
    bit                                tare_on = 1'b0;

    lcts_pkg::result_t expected_results[$];
    stim_row_t         directed_rows[$];
    lcts_pkg::result_t head;
    int                err_count = 0;
    int                idle_cycles = 0;
    int                send_idle_pct = 20;
    int                stall_pct = 20;
    bit                hold_request = 1'b0;

    load_cell_tare_and_smooth u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // tare accumulation, offset load and moving average for one accepted request
    function automatic lcts_pkg::result_t predict_load(input lcts_pkg::item_t req);
        logic signed [lcts_pkg::RAW_W-1:0] raw_s;
        longint                            a;
        longint                            a_one;
        longint                            acc;
        longint                            tared;
        lcts_pkg::result_t                 r;
        tared = 0;
        a_one = longint'(lcts_pkg::ALPHA_ONE);
        raw_s = req.raw_word;
        case (req.opcode)
            lcts_pkg::OP_SAMPLE:
            begin
                if (tare_on)
                begin
                    tare_acc  = tare_acc + raw_s;
                    tare_seen = (tare_seen + 1) & 4'hF;
                    if (tare_seen >= TARE_SAMPLES)
                    begin
                        // signed divide truncates toward zero
                        held_offset = lcts_pkg::RAW_W'(tare_acc / TARE_SAMPLES);
                        avg_q16     = 0;
                        tare_on     = 1'b0;
                        tare_seen   = 0;
                        tare_acc    = 0;
                    end
                end
                else
                begin
                    a       = (alpha_reg > lcts_pkg::ALPHA_ONE) ? a_one : longint'(alpha_reg);
                    tared   = longint'(raw_s) - longint'(held_offset);
                    acc     = a * (tared * 65536) + (a_one - a) * avg_q16;
                    avg_q16 = acc >>> lcts_pkg::FRAC_W;
                end
            end
            lcts_pkg::OP_TARE:
            begin
                tare_on   = 1'b1;
                tare_acc  = 0;
                tare_seen = 0;
            end
            lcts_pkg::OP_LOAD_OFFS:
            begin
                held_offset = req.new_offset_value;
            end
            default:
            begin
            end
        endcase
        r.avg_load       = lcts_pkg::SMOOTH_W'(avg_q16 >>> lcts_pkg::OUT_DROP);
        r.tared_counts   = lcts_pkg::TARED_W'(tared);
        r.current_offset = held_offset;
        r.taring         = tare_on;
        return r;
    endfunction

    function automatic lcts_pkg::result_t mk_result(input longint smooth, input longint tared,
                                                    input longint offs, input bit taring);
        lcts_pkg::result_t r;
        r.avg_load       = lcts_pkg::SMOOTH_W'(smooth);
        r.tared_counts   = lcts_pkg::TARED_W'(tared);
        r.current_offset = lcts_pkg::RAW_W'(offs);
        r.taring         = taring;
        return r;
    endfunction

    function automatic void add_row(input logic [lcts_pkg::OPCODE_W-1:0] op,
                                    input logic [23:0] raw,
                                    input logic [23:0] offs, input bit fixed,
                                    input lcts_pkg::result_t want);
        stim_row_t row;
        row.req.opcode           = op;
        row.req.raw_word         = raw;
        row.req.new_offset_value = offs;
        row.fixed                = fixed;
        row.want                 = want;
        directed_rows.push_back(row);
    endfunction

    // mostly samples so that tare runs complete, with tares, loads and stray opcodes mixed in
    function automatic lcts_pkg::item_t random_request();
        lcts_pkg::item_t req;
        int              pick;
        int              style;
        pick  = $urandom_range(99);
        style = $urandom_range(99);
        if (pick < 4)
            req.opcode = OP_UNUSED;
        else if (pick < 11)
            req.opcode = lcts_pkg::OP_TARE;
        else if (pick < 18)
            req.opcode = lcts_pkg::OP_LOAD_OFFS;
        else
            req.opcode = lcts_pkg::OP_SAMPLE;
        if (style < 15)
        begin
            case ($urandom_range(3))
                0: req.raw_word = 24'h000000;
                1: req.raw_word = 24'h7FFFFF;
                2: req.raw_word = 24'h800000;
                default: req.raw_word = 24'hFFFFFF;
            endcase
        end
        else if (style < 50)
            req.raw_word = 24'(int'(held_offset) + int'($urandom_range(128)) - 64);
        else
            req.raw_word = 24'($urandom);
        if ($urandom_range(99) < 20)
            req.new_offset_value = $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
        else if ($urandom_range(1))
            req.new_offset_value = 24'(int'($urandom_range(4096)) - 2048);
        else
            req.new_offset_value = 24'($urandom);
        return req;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name,
                                      $signed(got), $signed(want)));
    endtask

    task automatic send_request(input lcts_pkg::item_t req, input bit fixed,
                                input lcts_pkg::result_t want);
        lcts_pkg::result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {req.new_offset_value, req.raw_word};
        s_axis_tuser  <= req.opcode;
        do @(posedge clk); while (!s_axis_tready);
        predicted = predict_load(req);
        expected_results.push_back(fixed ? want : predicted);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
    endtask

    task automatic write_alpha(input logic [lcts_pkg::ALPHA_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        alpha_reg = value;
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // compare each result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with nothing expected");
            end
            else
            begin
                head = expected_results.pop_front();
                check_field("avg_load", 64'($signed(m_axis_tdata[32:0])),
                            64'(head.avg_load));
                check_field("tared_counts", 64'($signed(m_axis_tdata[57:33])),
                            64'(head.tared_counts));
                check_field("current_offset", 64'($signed(m_axis_tdata[81:58])),
                            64'(head.current_offset));
                check_field("taring", 64'(m_axis_tuser[0]), 64'(head.taring));
            end
        end
    end

    // watchdog on lack of progress
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("load_cell_tare_and_smooth verification failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // main sequence
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray opcode and offset loads right after reset, offset extremes
        add_row(OP_UNUSED, 24'hFFFFFF, 24'hFFFFFF, 1'b1, mk_result(0, 0, 0, 1'b0));
        add_row(lcts_pkg::OP_LOAD_OFFS, 24'h000000, 24'h7FFFFF, 1'b1,
                mk_result(0, 0, 8388607, 1'b0));
        add_row(lcts_pkg::OP_LOAD_OFFS, 24'hFFFFFF, 24'h800000, 1'b1,
                mk_result(0, 0, -8388608, 1'b0));
        // largest and smallest tared difference
        add_row(lcts_pkg::OP_SAMPLE, 24'h7FFFFF, 24'h000000, 1'b0, '0);
        add_row(lcts_pkg::OP_SAMPLE, 24'h800000, 24'h000000, 1'b0, '0);
        add_row(lcts_pkg::OP_LOAD_OFFS, 24'h000000, 24'h7FFFFF, 1'b0, '0);
        add_row(lcts_pkg::OP_SAMPLE, 24'h800000, 24'hFFFFFF, 1'b0, '0);
        add_row(lcts_pkg::OP_LOAD_OFFS, 24'hFFFFFF, 24'h000000, 1'b0, '0);
        // tare, interrupted by an offset load and a restart
        add_row(lcts_pkg::OP_TARE, 24'h000000, 24'h000000, 1'b0, '0);
        add_row(lcts_pkg::OP_SAMPLE, 24'h7FFFFF, 24'h000000, 1'b0, '0);
        add_row(lcts_pkg::OP_SAMPLE, 24'h800000, 24'h000000, 1'b0, '0);
        add_row(lcts_pkg::OP_SAMPLE, 24'hFFFFFF, 24'h000000, 1'b0, '0);
        add_row(lcts_pkg::OP_SAMPLE, 24'h000001, 24'h000000, 1'b0, '0);
        add_row(lcts_pkg::OP_LOAD_OFFS, 24'h000000, 24'h2AAAAA, 1'b0, '0);
        add_row(lcts_pkg::OP_TARE, 24'h000000, 24'h000000, 1'b0, '0);
        // nine samples of -1 and one zero: sum -9 truncates to offset 0
        for (int k = 0; k < TARE_SAMPLES - 1; k++)
            add_row(lcts_pkg::OP_SAMPLE, 24'hFFFFFF, 24'h000000, 1'b0, '0);
        add_row(lcts_pkg::OP_SAMPLE, 24'h000000, 24'h000000, 1'b1,
                mk_result(0, 0, 0, 1'b0));

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].want);

        // random phases, each under its own filter weight
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                1: write_alpha(lcts_pkg::ALPHA_ONE);
                2: write_alpha('0);
                3: write_alpha('1);
                4: write_alpha(17'd1);
                5: write_alpha(17'($urandom_range(131071)));
                default: ;
            endcase
            send_idle_pct = (ph == NUM_PHASES - 1) ? 0 : 20;
            stall_pct     = (ph == NUM_PHASES - 1) ? 0 : 20;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (ph == 1 && n == 100)
                    hold_request = 1'b1;
                if (ph == 3 && n == 130)
                    drain_results();
                send_request(random_request(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (4) @(posedge clk);
        if (err_count == 0)
            $display("load_cell_tare_and_smooth verification clean");
        else
            $display("load_cell_tare_and_smooth verification failed");
        $finish;
    end

endmodule
